### rtl/cdq_pkg.sv
// Shared definitions for the circular deque buffer: field widths, operation
// modes, status codes and the per-chain control word handed to the cell rows.
// No dependencies.
`default_nettype none

package cdq_pkg;

   // Payload field widths
   localparam int DATA_W   = 32;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Default number of stored words
   localparam int DEPTH_DEFAULT = 16;

   // Packed stream widths, rounded up to whole bytes
   localparam int REQ_BITS  = MODE_W + DATA_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS  = STATUS_W + COUNT_W + 1 + 1 + DATA_W + DATA_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Operation modes
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;
   localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd5;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // Cell row operations
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,  // keep the stored word
      OP_INSERT = 2'd1,  // shift away from the anchored end, new word at cell 0
      OP_REMOVE = 2'd2,  // shift toward the anchored end, dropping cell 0
      OP_APPEND = 2'd3   // write the new word into the cell at the fill count
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [DATA_W-1:0] wdata;
   } chain_ctrl_type;

endpackage

`default_nettype wire

### rtl/cdq_cell.sv
// One storage cell of a deque row: holds one word and takes its neighbor's
// word, the incoming word or its own on each clock. Depends on cdq_pkg.
`default_nettype none

module cdq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  wire logic                       clock,
   input  wire cdq_pkg::chain_ctrl_type    ctrl,
   input  wire logic [CNT_W-1:0]           count,
   input  wire logic [cdq_pkg::DATA_W-1:0] left_data,
   input  wire logic [cdq_pkg::DATA_W-1:0] right_data,
   output logic      [cdq_pkg::DATA_W-1:0] data_out,
   output logic      [cdq_pkg::DATA_W-1:0] data_next
);
   import cdq_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // Pick the next word from the row operation
   always_comb begin
      unique case (ctrl.op)
         OP_HOLD:   data_in = data_ff;
         OP_INSERT: data_in = left_data;
         OP_REMOVE: data_in = right_data;
         OP_APPEND: data_in = (count == CNT_W'(INDEX)) ? ctrl.wdata : data_ff;
         default:   data_in = data_ff;
      endcase
   end

   // Payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out  = data_ff;
   assign data_next = data_in;

endmodule

`default_nettype wire

### rtl/cdq_chain.sv
// Row of DEPTH deque cells anchored at cell 0; the row shifts in either
// direction or appends at the fill count. Depends on cdq_pkg and cdq_cell.
`default_nettype none

module cdq_chain #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                       clock,
   input  wire cdq_pkg::chain_ctrl_type    ctrl,
   input  wire logic [CNT_W-1:0]           count,
   output logic      [cdq_pkg::DATA_W-1:0] head_next
);
   import cdq_pkg::*;

   logic [DATA_W-1:0] cell_data [DEPTH];
   logic [DATA_W-1:0] cell_next [DEPTH];

   // Build the row; the ends take the incoming word and their own word
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_word;
      logic [DATA_W-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = ctrl.wdata;
      end else begin : g_inner_left
         assign left_word = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_word = cell_data[i];
      end else begin : g_inner_right
         assign right_word = cell_data[i+1];
      end

      cdq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count),
         .left_data  (left_word),
         .right_data (right_word),
         .data_out   (cell_data[i]),
         .data_next  (cell_next[i])
      );
   end

   // Word that cell 0 holds after this clock
   assign head_next = cell_next[0];

endmodule

`default_nettype wire

### rtl/circular_deque_buffer.sv
// Double-ended queue of DEPTH signed 32-bit words with a streaming request
// and response channel. Depends on cdq_pkg and cdq_chain.
//
// Each request transaction carries one operation (push back, push front, pop
// back, pop front, clear or query) and yields exactly one response
// transaction, registered in the cycle after acceptance, with the status, the
// count after the step, empty and full flags and the front and back words
// (zero when empty). The words live in two rows of cells, one anchored at the
// front and one at the back, so both ends are always at cell 0 of a row and
// every operation takes effect as it is accepted. A new request is taken
// every cycle as long as the response register is free or being drained, so
// the sustained rate is one transaction per cycle. No clearing pass is needed
// after reset.
`default_nettype none

module circular_deque_buffer #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [2:0] mode, [34:3] value, [39:35] zero
   input  wire logic [cdq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Response channel
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [1:0] status, [6:2] count, [7] is_empty, [8] is_full,
   // [40:9] front_value, [72:41] back_value, [79:73] zero
   output logic      [cdq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import cdq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                req_accept;
   logic [MODE_W-1:0]   req_mode;
   logic [DATA_W-1:0]   req_value;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                is_empty_now;
   logic                is_full_now;
   logic [STATUS_W-1:0] status_in;

   chain_ctrl_type      front_ctrl;
   chain_ctrl_type      back_ctrl;
   logic [DATA_W-1:0]   front_next;
   logic [DATA_W-1:0]   back_next;

   logic                          empty_in;
   logic                          full_in;
   logic [COUNT_W+CNT_W-1:0]      count_ext;
   logic                          rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]        rsp_data_ff;
   logic [RSP_TDATA_W-1:0]        rsp_data_in;

   assign req_mode   = req_tdata[MODE_W-1:0];
   assign req_value  = req_tdata[MODE_W+DATA_W-1:MODE_W];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign is_empty_now = (count_ff == '0);
   assign is_full_now  = (count_ff == CNT_W'(DEPTH));

   // Decode the operation into row controls, new count and status
   always_comb begin
      status_in        = STATUS_DONE;
      count_in         = count_ff;
      front_ctrl.op    = OP_HOLD;
      front_ctrl.wdata = req_value;
      back_ctrl.op     = OP_HOLD;
      back_ctrl.wdata  = req_value;
      if (req_accept) begin
         unique case (req_mode)
            MODE_PUSH_BACK: begin
               if (is_full_now) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in      = count_ff + CNT_W'(1);
                  front_ctrl.op = OP_APPEND;
                  back_ctrl.op  = OP_INSERT;
               end
            end
            MODE_PUSH_FRONT: begin
               if (is_full_now) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in      = count_ff + CNT_W'(1);
                  front_ctrl.op = OP_INSERT;
                  back_ctrl.op  = OP_APPEND;
               end
            end
            MODE_POP_BACK: begin
               if (is_empty_now) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  count_in     = count_ff - CNT_W'(1);
                  back_ctrl.op = OP_REMOVE;
               end
            end
            MODE_POP_FRONT: begin
               if (is_empty_now) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  count_in      = count_ff - CNT_W'(1);
                  front_ctrl.op = OP_REMOVE;
               end
            end
            MODE_CLEAR: begin
               count_in = '0;
            end
            default: begin
               // query and unused modes leave the deque alone
            end
         endcase
      end
   end

   // Front-anchored and back-anchored rows
   cdq_chain #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_front_chain (
      .clock     (clock),
      .ctrl      (front_ctrl),
      .count     (count_ff),
      .head_next (front_next)
   );

   cdq_chain #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_back_chain (
      .clock     (clock),
      .ctrl      (back_ctrl),
      .count     (count_ff),
      .head_next (back_next)
   );

   // Pack the response from the state after this step
   assign empty_in  = (count_in == '0);
   assign full_in   = (count_in == CNT_W'(DEPTH));
   assign count_ext = {{COUNT_W{1'b0}}, count_in};

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[STATUS_W-1:0]                  = status_in;
      rsp_data_in[STATUS_W+COUNT_W-1:STATUS_W]   = count_ext[COUNT_W-1:0];
      rsp_data_in[STATUS_W+COUNT_W]              = empty_in;
      rsp_data_in[STATUS_W+COUNT_W+1]            = full_in;
      rsp_data_in[STATUS_W+COUNT_W+2+DATA_W-1:STATUS_W+COUNT_W+2] =
         empty_in ? '0 : front_next;
      rsp_data_in[STATUS_W+COUNT_W+2+2*DATA_W-1:STATUS_W+COUNT_W+2+DATA_W] =
         empty_in ? '0 : back_next;
   end

   // Advance count and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the response payload until taken
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/cdq_checker.sv
// Port-level checks for the circular deque buffer, attached by bind.
// Depends on cdq_pkg and the circular_deque_buffer top level.
`default_nettype none

module cdq_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [cdq_pkg::REQ_TDATA_W-1:0] req_tdata,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [cdq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import cdq_pkg::*;

   logic                req_xfer;
   logic                rsp_empty;
   logic                rsp_full;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_count;
   logic [DATA_W-1:0]   rsp_front;
   logic [DATA_W-1:0]   rsp_back;

   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_status = rsp_tdata[1:0];
   assign rsp_count  = rsp_tdata[6:2];
   assign rsp_empty  = rsp_tdata[7];
   assign rsp_full   = rsp_tdata[8];
   assign rsp_front  = rsp_tdata[40:9];
   assign rsp_back   = rsp_tdata[72:41];

   // No response right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // An empty deque reports zero count, zero end words and no full flag
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_empty |-> rsp_count == '0 && rsp_front == '0 && rsp_back == '0
      && !rsp_full)
      else $error("empty response carries data");

   // Clear always succeeds and empties the deque in the next response
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tdata[MODE_W-1:0] == MODE_CLEAR
      |=> rsp_tvalid && rsp_empty && rsp_status == STATUS_DONE)
      else $error("clear did not empty the deque");

   // Every accepted request yields a response on the next cycle
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_tvalid)
      else $error("request without response");

endmodule

bind circular_deque_buffer cdq_checker u_cdq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### tb/circular_deque_buffer_test.sv
// Self-checking regression for circular_deque_buffer: directed and random deque operations
// with per-field response checks against a behavioral deque model kept in this file.
// Depends on cdq_pkg and the circular_deque_buffer RTL.
`default_nettype none

module circular_deque_buffer_test;
   import cdq_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 8;

   // Modes beyond query behave as query
   localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic                is_empty;
      logic                is_full;
      logic [DATA_W-1:0]   front_value;
      logic [DATA_W-1:0]   back_value;
   } deque_view_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // [2:0] mode, [34:3] value, [39:35] zero
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // [1:0] status, [6:2] count, [7] is_empty, [8] is_full,
   // [40:9] front_value, [72:41] back_value, [79:73] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Deque model state
   logic [DATA_W-1:0] ring_words [DEPTH];
   int                head_slot;
   int                tail_slot;
   int                fill_level;

   deque_view_type pending_views[$];
   int             error_count;
   int             cycle_count;
   int             sender_idle_pct;
   int             receiver_stall_pct;

   circular_deque_buffer #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Apply one operation to the deque model and return what the block should report
   function automatic deque_view_type apply_deque_op(input logic [MODE_W-1:0] mode,
                                                     input logic [DATA_W-1:0] value);
      deque_view_type v;
      v.status = STATUS_DONE;
      case (mode)
         MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
            if (fill_level >= DEPTH) begin
               v.status = STATUS_FULL;
            end else if (fill_level == 0) begin
               head_slot     = 0;
               tail_slot     = 0;
               ring_words[0] = value;
               fill_level    = 1;
            end else if (mode == MODE_PUSH_BACK) begin
               tail_slot             = (tail_slot == DEPTH - 1) ? 0 : tail_slot + 1;
               ring_words[tail_slot] = value;
               fill_level++;
            end else begin
               head_slot             = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
               ring_words[head_slot] = value;
               fill_level++;
            end
         end
         MODE_POP_BACK, MODE_POP_FRONT: begin
            if (fill_level == 0) begin
               v.status = STATUS_EMPTY;
            end else if (fill_level == 1) begin
               head_slot  = 0;
               tail_slot  = 0;
               fill_level = 0;
            end else begin
               if (mode == MODE_POP_BACK)
                  tail_slot = (tail_slot == 0) ? DEPTH - 1 : tail_slot - 1;
               else
                  head_slot = (head_slot == DEPTH - 1) ? 0 : head_slot + 1;
               fill_level--;
            end
         end
         MODE_CLEAR: begin
            head_slot  = 0;
            tail_slot  = 0;
            fill_level = 0;
         end
         default: ;
      endcase
      v.count       = fill_level[COUNT_W-1:0];
      v.is_empty    = (fill_level == 0);
      v.is_full     = (fill_level >= DEPTH);
      v.front_value = v.is_empty ? '0 : ring_words[head_slot];
      v.back_value  = v.is_empty ? '0 : ring_words[tail_slot];
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("mismatch: %s got %h expected %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // Predict on each accepted request, then check each accepted response
   always @(posedge clock) begin
      deque_view_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            pending_views.push_back(apply_deque_op(req_tdata[2:0], req_tdata[34:3]));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_views.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata[31:0], '0);
            end else begin
               want = pending_views.pop_front();
               if (rsp_tdata[1:0] !== want.status)
                  report_mismatch("status", DATA_W'(rsp_tdata[1:0]), DATA_W'(want.status));
               if (rsp_tdata[6:2] !== want.count)
                  report_mismatch("count", DATA_W'(rsp_tdata[6:2]), DATA_W'(want.count));
               if (rsp_tdata[7] !== want.is_empty)
                  report_mismatch("is_empty", DATA_W'(rsp_tdata[7]), DATA_W'(want.is_empty));
               if (rsp_tdata[8] !== want.is_full)
                  report_mismatch("is_full", DATA_W'(rsp_tdata[8]), DATA_W'(want.is_full));
               if (rsp_tdata[40:9] !== want.front_value)
                  report_mismatch("front_value", rsp_tdata[40:9], want.front_value);
               if (rsp_tdata[72:41] !== want.back_value)
                  report_mismatch("back_value", rsp_tdata[72:41], want.back_value);
            end
         end
      end
   end

   // Stall the response channel at the current rate
   always @(negedge clock) begin
      if (!reset)
         rsp_tready = ($urandom_range(99, 0) >= receiver_stall_pct);
   end

   // Hard stop on a hang
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("circular_deque_buffer regression: fail");
         $finish;
      end
   end

   // Offer one request transaction and hold it until accepted
   task automatic send_op(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {5'd0, value, mode};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every predicted response has come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(9, 0))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_empty_edges();
      send_op(MODE_POP_BACK, 32'h1234_5678);
      send_op(MODE_POP_FRONT, 32'hffff_ffff);
      send_op(MODE_QUERY, 32'h0);
      send_op(MODE_CLEAR, 32'h0);
   endtask

   task automatic test_end_values();
      send_op(MODE_PUSH_BACK, 32'h8000_0000);
      send_op(MODE_PUSH_FRONT, 32'h7fff_ffff);
      send_op(MODE_POP_BACK, 32'h0);
      send_op(MODE_POP_FRONT, 32'h0);
      send_op(MODE_PUSH_FRONT, 32'hffff_ffff);
      send_op(MODE_POP_BACK, 32'h0);
   endtask

   // Fill from both ends, hit the full refusal on each side, query through the spare modes, then clear
   task automatic test_full_edges();
      for (int i = 0; i < DEPTH; i++)
         send_op(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK, 32'hA5A5_0000 + i);
      send_op(MODE_PUSH_BACK, 32'hdead_beef);
      send_op(MODE_PUSH_FRONT, 32'hdead_beef);
      send_op(MODE_SPARE_6, 32'hffff_ffff);
      send_op(MODE_SPARE_7, 32'hffff_ffff);
      send_op(MODE_CLEAR, 32'h0);
   endtask

   // Random traffic that swings between filling and draining
   task automatic test_random_traffic(input int items, input int idle_pct,
                                      input int stall_pct);
      bit                grow;
      int                r;
      logic [MODE_W-1:0] mode;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      grow = 1'b1;
      for (int n = 0; n < items; n++) begin
         if (fill_level >= DEPTH)
            grow = 1'b0;
         else if (fill_level == 0)
            grow = 1'b1;
         else if ($urandom_range(99, 0) < 3)
            grow = ~grow;
         r = $urandom_range(99, 0);
         if (r < 2)
            mode = MODE_CLEAR;
         else if (r < 5)
            mode = MODE_W'($urandom_range(MODE_SPARE_7, MODE_QUERY));
         else if ($urandom_range(99, 0) < (grow ? 70 : 30))
            mode = $urandom_range(1, 0) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
         else
            mode = $urandom_range(1, 0) ? MODE_POP_FRONT : MODE_POP_BACK;
         send_op(mode, pick_value());
      end
   endtask

   // Let the pipeline run dry mid-stream, then resume
   task automatic test_pause_until_drained();
      test_random_traffic(20, 0, 30);
      wait_drained();
      test_random_traffic(20, 0, 30);
   endtask

   initial begin
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      rsp_tready         = 1'b0;
      error_count        = 0;
      cycle_count        = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      head_slot          = 0;
      tail_slot          = 0;
      fill_level         = 0;
      foreach (ring_words[i]) ring_words[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_edges();
      test_end_values();
      test_full_edges();
      test_random_traffic(360, 0, 0);
      test_random_traffic(360, 82, 0);
      test_random_traffic(360, 0, 82);
      test_random_traffic(360, 22, 22);
      test_pause_until_drained();

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("circular_deque_buffer regression: pass");
      else
         $display("circular_deque_buffer regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/cdq_pkg.sv
rtl/cdq_cell.sv
rtl/cdq_chain.sv
rtl/circular_deque_buffer.sv
rtl/cdq_checker.sv
tb/circular_deque_buffer_test.sv
